// ===== sv/isr_pkg.sv =====
// shared constants for the integer square root core
// no dependencies; used by isr_stage and integer_square_root_core
package isr_pkg;

  // port widths of the radicand and root fields
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;

  // default radicand width and the matching number of bit pairs
  localparam int WIDTH_DEF = 64;
  localparam int PAIRS_DEF = (WIDTH_DEF + 1) / 2;

endpackage

// ===== sv/integer_square_root_core.sv =====
// top level of the pipelined integer square root core
// depends on isr_pkg and isr_stage
//
// Returns floor(sqrt(radicand)) for an unsigned radicand, of which only the low
// WIDTH bits count (an odd WIDTH is padded with a zero bit at the top). A
// radicand transfers at every rising edge with start high and busy low; busy
// is always low, so a new radicand can be given in every cycle. The core is a
// pipeline of (WIDTH+1)/2 register stages, one per root bit, each holding a
// single trial subtract of about WIDTH/2+2 bits. The root of a radicand
// appears on out_root with out_valid high for exactly one cycle once it has
// passed through every stage register in turn, in the order the radicands
// came in. There is no hold-off from the receiver: each result must be taken
// in the cycle it is shown.
module integer_square_root_core #(
  parameter int WIDTH = isr_pkg::WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [isr_pkg::RAD_W-1:0]  in_radicand,
  output logic                       out_valid,
  output logic [isr_pkg::ROOT_W-1:0] out_root
);

  localparam int PAIRS  = (WIDTH + 1) / 2;
  localparam int REM_W  = PAIRS + 2;
  localparam int RAD_PW = 2 * PAIRS;

  // per-stage buses; index 0 is the pipeline entry, index PAIRS the output
  logic              vld_s  [0:PAIRS];
  logic [REM_W-1:0]  rem_s  [0:PAIRS];
  logic [PAIRS-1:0]  root_s [0:PAIRS];
  logic [RAD_PW-1:0] rad_s  [0:PAIRS];

  // pipeline never stalls, so the core is always ready
  assign busy = 1'b0;

  // entry: masked radicand, zero-padded to a whole number of pairs
  assign vld_s[0]  = start & ~busy;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = RAD_PW'(in_radicand[WIDTH-1:0]);

  // one stage per root bit, top pair first
  for (genvar g = 0; g < PAIRS; g++) begin : g_stage
    isr_stage #(
      .PAIRS (PAIRS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld_s[g]),
      .in_rem    (rem_s[g]),
      .in_root   (root_s[g]),
      .in_rad    (rad_s[g]),
      .out_valid (vld_s[g+1]),
      .out_rem   (rem_s[g+1]),
      .out_root  (root_s[g+1]),
      .out_rad   (rad_s[g+1])
    );
  end

  // result: root widened to the port, strobe straight from the last valid bit
  assign out_valid = vld_s[PAIRS];
  assign out_root  = isr_pkg::ROOT_W'(root_s[PAIRS]);

  // a result only ever comes from a transfer exactly the pipeline depth earlier
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PAIRS))
    else $error("result strobe without a matching transfer");

  // root squared never exceeds the radicand it came from
  a_root_low : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (66'(out_root) * 66'(out_root)
                   <= 66'($past(in_radicand[WIDTH-1:0], PAIRS))))
    else $error("root too large");

  // the next integer up squares past the radicand
  a_root_high : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((66'(out_root) + 66'd1) * (66'(out_root) + 66'd1)
                   > 66'($past(in_radicand[WIDTH-1:0], PAIRS))))
    else $error("root too small");

endmodule

// ===== sv/isr_stage.sv =====
// one restoring square root step: shift in a bit pair, trial subtract, register
// depends on isr_pkg for the default pair count
module isr_stage #(
  parameter int PAIRS = isr_pkg::PAIRS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [PAIRS+1:0]     in_rem,
  input  logic [PAIRS-1:0]     in_root,
  input  logic [2*PAIRS-1:0]   in_rad,
  output logic                 out_valid,
  output logic [PAIRS+1:0]     out_rem,
  output logic [PAIRS-1:0]     out_root,
  output logic [2*PAIRS-1:0]   out_rad
);

  localparam int REM_W = PAIRS + 2;
  localparam int RAD_PW = 2 * PAIRS;

  logic                valid_r;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [PAIRS-1:0]    root_r, root_nxt;
  logic [RAD_PW-1:0]   rad_r, rad_nxt;

  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic [REM_W:0]      diff;
  logic                fits;
  logic [PAIRS:0]      root_ext;
  logic [RAD_PW+1:0]   rad_ext;

  always_comb begin
    // remainder stays below 2^PAIRS between steps, so the top two bits drop safely
    rem_sh   = {in_rem[REM_W-3:0], in_rad[RAD_PW-1 -: 2]};
    trial    = {in_root, 2'b01};
    diff     = {1'b0, rem_sh} - {1'b0, trial};
    fits     = ~diff[REM_W];
    rem_nxt  = fits ? diff[REM_W-1:0] : rem_sh;
    root_ext = {in_root, fits};
    root_nxt = root_ext[PAIRS-1:0];
    rad_ext  = {in_rad, 2'b00};
    rad_nxt  = rad_ext[RAD_PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= rad_nxt;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_rad   = rad_r;

endmodule
